// ===== rtl/core/grid_mesh_index_generator_assert.svh =====
// Assertion macros for the grid mesh index generator.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef GRID_MESH_INDEX_GENERATOR_ASSERT_SVH
`define GRID_MESH_INDEX_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define GMIG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define GMIG_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define GMIG_ASSERT(label, prop, msg)

`define GMIG_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ===== rtl/core/gmig_pkg.sv =====
`timescale 1ns / 1ps

package gmig_pkg;

	localparam int MAX_DIVISIONS = 31;
	localparam int DIV_W   = 5;
	localparam int IDX_W   = 10;
	localparam int CNT_W   = 6;   // result counter, up to 64 results
	localparam int STRD_W  = 6;   // rows + 1, up to 32

	// Register indexes
	localparam logic [1:0] REG_COLS  = 2'd0;
	localparam logic [1:0] REG_ROWS  = 2'd1;
	localparam logic [1:0] REG_KIND  = 2'd2;
	localparam logic [1:0] REG_RULE  = 2'd3;

	// Primitive kinds
	localparam logic [1:0] KIND_TSTRIP = 2'd0;
	localparam logic [1:0] KIND_TFAN   = 2'd1;
	localparam logic [1:0] KIND_QSTRIP = 2'd2;
	localparam logic [1:0] KIND_QUAD   = 2'd3;

	// Triangle rules
	localparam logic RULE_LLUR = 1'b0;
	localparam logic RULE_ULLR = 1'b1;

	// Run modes handed from front to back
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_BAD  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_COL  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROW  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUAD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FAN  = 3'd4;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [DIV_W-1:0] cols;
		logic [DIV_W-1:0] rows;
		logic [1:0]       kind;
		logic             rule;
	} gmig_cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  base;   // vertex A of the run
		logic [STRD_W-1:0] stride; // rows + 1
		logic [CNT_W-1:0]  last;   // number of results minus one
	} gmig_desc_t;

endpackage

// ===== rtl/core/gmig_front.sv =====
`timescale 1ns / 1ps

module gmig_front (
	input  gmig_pkg::gmig_cfg_t              cfg,
	input  logic                             in_valid,
	input  logic [gmig_pkg::DIV_W-1:0]       cell_row,
	input  logic [gmig_pkg::DIV_W-1:0]       cell_column,
	input  logic                             q_full,
	output logic                             in_stall,
	output logic                             push,
	output gmig_pkg::gmig_desc_t             desc
);
	import gmig_pkg::*;

	logic                 col_strip;
	logic                 row_strip;
	logic                 row_ok;
	logic                 col_ok;
	logic                 ok;
	logic [STRD_W-1:0]    stride;
	logic [DIV_W-1:0]     r_eff;
	logic [DIV_W-1:0]     c_eff;
	logic [STRD_W+DIV_W-1:0] prod;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		col_strip = (cfg.kind == KIND_QSTRIP) ||
			(cfg.kind == KIND_TSTRIP && cfg.rule == RULE_ULLR);
		row_strip = (cfg.kind == KIND_TSTRIP && cfg.rule == RULE_LLUR);
		row_ok    = cell_row < cfg.rows;
		col_ok    = cell_column < cfg.cols;
		if (col_strip) begin
			ok = col_ok;
		end else if (row_strip) begin
			ok = row_ok;
		end else begin
			ok = row_ok && col_ok;
		end

		stride = STRD_W'({1'b0, cfg.rows}) + STRD_W'(1);
		r_eff  = col_strip ? '0 : cell_row;
		c_eff  = row_strip ? '0 : cell_column;
		prod   = (STRD_W+DIV_W)'(stride) * (STRD_W+DIV_W)'(c_eff);

		desc.stride = stride;
		desc.base   = IDX_W'(prod + (STRD_W+DIV_W)'(r_eff));
		if (!ok) begin
			desc.mode = MODE_BAD;
			desc.last = '0;
		end else if (col_strip) begin
			desc.mode = MODE_COL;
			desc.last = {cfg.rows, 1'b1};
		end else if (row_strip) begin
			desc.mode = MODE_ROW;
			desc.last = {cfg.cols, 1'b1};
		end else if (cfg.kind == KIND_TFAN && cfg.rule == RULE_ULLR) begin
			desc.mode = MODE_FAN;
			desc.last = CNT_W'(3);
		end else begin
			desc.mode = MODE_QUAD;
			desc.last = CNT_W'(3);
		end
	end

endmodule

// ===== rtl/core/gmig_queue.sv =====
`timescale 1ns / 1ps

module gmig_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  gmig_pkg::gmig_desc_t  desc_in,
	output logic                  full,
	input  logic                  pop,
	output logic                  q_valid,
	output gmig_pkg::gmig_desc_t  desc_out
);
	import gmig_pkg::*;

	gmig_desc_t        entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == QCNT_W'(QDEPTH);
	assign q_valid  = count_q != '0;
	assign desc_out = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && q_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QDEPTH - 1)) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= desc_in;
		end
	end

endmodule

// ===== rtl/core/gmig_back.sv =====
`timescale 1ns / 1ps
`include "grid_mesh_index_generator_assert.svh"

module gmig_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  gmig_pkg::gmig_desc_t        q_desc,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [gmig_pkg::IDX_W-1:0]  vertex_index,
	output logic                        last_in_run,
	output logic                        bad_request
);
	import gmig_pkg::*;

	gmig_desc_t        cur_q;
	logic              busy_q;
	logic [CNT_W-1:0]  k_q;
	logic [IDX_W-1:0]  p_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;
	logic              bad_q;

	logic              advance;
	logic              last_hit;
	logic              load;
	logic [STRD_W:0]   off;
	logic [STRD_W:0]   s_ext;
	logic [IDX_W-1:0]  index_d;

	assign advance  = busy_q && (!out_valid_q || !out_stall);
	assign last_hit = k_q == cur_q.last;
	assign load     = q_valid && (!busy_q || (advance && last_hit));
	assign pop      = load;

	assign out_valid    = out_valid_q;
	assign vertex_index = index_q;
	assign last_in_run  = last_q;
	assign bad_request  = bad_q;

	// offset of the current index from the walking base
	always_comb begin
		s_ext = {1'b0, cur_q.stride};
		off   = '0;
		case (cur_q.mode)
			MODE_COL: begin
				off = k_q[0] ? s_ext : '0;
			end
			MODE_ROW: begin
				off = k_q[0] ? '0 : (STRD_W+1)'(1);
			end
			MODE_QUAD: begin
				case (k_q[1:0])
					2'd0:    off = '0;
					2'd1:    off = s_ext;
					2'd2:    off = s_ext + (STRD_W+1)'(1);
					default: off = (STRD_W+1)'(1);
				endcase
			end
			MODE_FAN: begin
				case (k_q[1:0])
					2'd0:    off = s_ext;
					2'd1:    off = s_ext + (STRD_W+1)'(1);
					2'd2:    off = (STRD_W+1)'(1);
					default: off = '0;
				endcase
			end
			default: off = '0;
		endcase
		if (cur_q.mode == MODE_BAD) begin
			index_d = '0;
		end else begin
			index_d = p_q + IDX_W'(off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (advance && last_hit) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_desc;
			p_q   <= q_desc.base;
		end else if (advance && k_q[0]) begin
			if (cur_q.mode == MODE_COL) begin
				p_q <= p_q + IDX_W'(1);
			end else if (cur_q.mode == MODE_ROW) begin
				p_q <= p_q + IDX_W'(cur_q.stride);
			end
		end
		if (advance) begin
			index_q <= index_d;
			last_q  <= last_hit;
			bad_q   <= cur_q.mode == MODE_BAD;
		end
	end

	`GMIG_ASSERT(a_bad_single, (out_valid_q && bad_q) |-> (last_q && index_q == '0), "bad result must be a lone zero index")
	`GMIG_ASSERT(a_k_bound, busy_q |-> (k_q <= cur_q.last), "result counter ran past end of run")
	`GMIG_ASSERT(a_busy_holds, (advance && !last_hit) |=> busy_q, "run ended before its last index")
	`GMIG_ASSERT_NEVER(a_short_run, busy_q && cur_q.mode == MODE_QUAD && cur_q.last != CNT_W'(3), "quad run must hold four indices")

endmodule

// ===== rtl/core/grid_mesh_index_generator.sv =====
`timescale 1ns / 1ps
// Grid mesh index generator: emits vertex-index runs for a regular grid mesh
// whose vertices are numbered column-major, (rows+1)*col + row.
// Input channel: in_valid / in_stall with cell_row, cell_column; a transaction
//   names one primitive of the kind selected in the configuration registers.
// Output channel: out_valid / out_stall with vertex_index, last_in_run and
//   bad_request; one transaction per index, last_in_run on the final one.
//   A request outside the grid gives a single transaction: index 0,
//   last_in_run 1, bad_request 1.
// Config: cfg_we writes cfg_data into register cfg_index (0 column divisions,
//   1 row divisions, 2 primitive kind, 3 triangle rule); write only when idle.
// Path: requests pass the descriptor queue, walker and output register.
// Throughput: one index per cycle from the back-end walker unless the
//   output is stalled; a run holds 2*(divisions+1) indices for a strip (up
//   to 64), 4 for a fan or quad, 1 for a bad request. Runs leave no gap.
// A two-entry descriptor queue separates the classifying front end from the
// walker, so inputs keep being accepted while the output is stalled, until
// the queue fills. A stalled output holds its transaction unchanged.
// Reset (arst_n low) empties the queue and output register and loads the
// default grid: 10 x 10 cells, triangle strip, lower-left to upper-right.

module grid_mesh_index_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [gmig_pkg::DIV_W-1:0]  cell_row,
	input  logic [gmig_pkg::DIV_W-1:0]  cell_column,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [gmig_pkg::IDX_W-1:0]  vertex_index,
	output logic                        last_in_run,
	output logic                        bad_request,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [gmig_pkg::DIV_W-1:0]  cfg_data
);
	import gmig_pkg::*;

	gmig_cfg_t  cfg_q;
	gmig_desc_t front_desc;
	gmig_desc_t q_desc;
	logic       push;
	logic       q_full;
	logic       q_valid;
	logic       pop;

	// Configuration registers; 5-bit divisions never exceed MAX_DIVISIONS.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols <= DIV_W'(10);
			cfg_q.rows <= DIV_W'(10);
			cfg_q.kind <= KIND_TSTRIP;
			cfg_q.rule <= RULE_LLUR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLS: cfg_q.cols <= cfg_data;
				REG_ROWS: cfg_q.rows <= cfg_data;
				REG_KIND: cfg_q.kind <= cfg_data[1:0];
				REG_RULE: cfg_q.rule <= cfg_data[0];
				default:  cfg_q      <= cfg_q;
			endcase
		end
	end

	// Front end: bounds check, run mode, base vertex and run length.
	gmig_front u_front (
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.cell_row    (cell_row),
		.cell_column (cell_column),
		.q_full      (q_full),
		.in_stall    (in_stall),
		.push        (push),
		.desc        (front_desc)
	);

	// Descriptor queue between front and back.
	gmig_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.desc_in  (front_desc),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.desc_out (q_desc)
	);

	// Back end: walks the run, one index per cycle when not stalled, to output.
	gmig_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_desc       (q_desc),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.last_in_run  (last_in_run),
		.bad_request  (bad_request)
	);

endmodule

// ===== tb/grid_mesh_index_checker.sv =====
`timescale 1ns / 1ps

module grid_mesh_index_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [gmig_pkg::DIV_W-1:0] cell_row,
	input  logic [gmig_pkg::DIV_W-1:0] cell_column,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [gmig_pkg::IDX_W-1:0] vertex_index,
	input  logic                       last_in_run,
	input  logic                       bad_request,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [gmig_pkg::DIV_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending,
	output int                         checked
);
	import gmig_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] vtx;
		logic             last;
		logic             bad;
	} mesh_result_t;

	logic [DIV_W-1:0] grid_cols;
	logic [DIV_W-1:0] grid_rows;
	logic [1:0]       grid_kind;
	logic             grid_rule;
	mesh_result_t     expected_indices[$];
	mesh_result_t     want;
	int               err_cnt = 0;
	int               pend_cnt = 0;
	int               chk_cnt = 0;

	assign errors  = err_cnt;
	assign pending = pend_cnt;
	assign checked = chk_cnt;

	function automatic logic [IDX_W-1:0] grid_vertex(input int rows, input int vr, input int vc);
		int flat;
		flat = (rows + 1) * vc + vr;
		return flat[IDX_W-1:0];
	endfunction

	function automatic void push_index(input logic [IDX_W-1:0] vtx, input logic last,
			input logic bad);
		mesh_result_t res;
		res.vtx = vtx;
		res.last = last;
		res.bad = bad;
		expected_indices.push_back(res);
	endfunction

	// Expected index run for one requested primitive under the current grid.
	function automatic void predict_run(input logic [DIV_W-1:0] cr, input logic [DIV_W-1:0] cc);
		int cols, rows, r, c, n;
		bit col_strip, row_strip, in_grid;
		logic [IDX_W-1:0] seq[64];
		logic [IDX_W-1:0] corner_a, corner_b, corner_c, corner_d;
		cols = int'(grid_cols);
		rows = int'(grid_rows);
		r = int'(cr);
		c = int'(cc);
		n = 0;
		col_strip = (grid_kind == KIND_QSTRIP) ||
			(grid_kind == KIND_TSTRIP && grid_rule == RULE_ULLR);
		row_strip = (grid_kind == KIND_TSTRIP) && (grid_rule == RULE_LLUR);
		if (col_strip)
			in_grid = c < cols;
		else if (row_strip)
			in_grid = r < rows;
		else
			in_grid = (r < rows) && (c < cols);
		if (!in_grid) begin
			push_index('0, 1'b1, 1'b1);
			return;
		end
		if (col_strip) begin
			for (int i = 0; i <= rows; i++) begin
				seq[n] = grid_vertex(rows, i, c);
				seq[n + 1] = grid_vertex(rows, i, c + 1);
				n = n + 2;
			end
		end else if (row_strip) begin
			for (int i = 0; i <= cols; i++) begin
				seq[n] = grid_vertex(rows, r + 1, i);
				seq[n + 1] = grid_vertex(rows, r, i);
				n = n + 2;
			end
		end else begin
			corner_a = grid_vertex(rows, r, c);
			corner_b = grid_vertex(rows, r, c + 1);
			corner_c = grid_vertex(rows, r + 1, c);
			corner_d = grid_vertex(rows, r + 1, c + 1);
			if (grid_kind == KIND_TFAN && grid_rule == RULE_ULLR) begin
				seq[0] = corner_b;
				seq[1] = corner_d;
				seq[2] = corner_c;
				seq[3] = corner_a;
			end else begin
				seq[0] = corner_a;
				seq[1] = corner_b;
				seq[2] = corner_d;
				seq[3] = corner_c;
			end
			n = 4;
		end
		for (int i = 0; i < n; i++)
			push_index(seq[i], i == n - 1, 1'b0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols = 5'd10;
			grid_rows = 5'd10;
			grid_kind = KIND_TSTRIP;
			grid_rule = RULE_LLUR;
			expected_indices.delete();
		end else begin
			// request uses the grid as it stood before this edge
			if (in_valid && !in_stall)
				predict_run(cell_row, cell_column);
			if (cfg_we) begin
				case (cfg_index)
					REG_COLS: grid_cols = cfg_data;
					REG_ROWS: grid_rows = cfg_data;
					REG_KIND: grid_kind = cfg_data[1:0];
					REG_RULE: grid_rule = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				chk_cnt++;
				if (expected_indices.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected transaction, expected none, got index %0d last %0b bad %0b",
						$time, vertex_index, last_in_run, bad_request);
				end else begin
					want = expected_indices.pop_front();
					if (vertex_index !== want.vtx) begin
						err_cnt++;
						$display("%0t: vertex_index expected %0d actual %0d",
							$time, want.vtx, vertex_index);
					end
					if (last_in_run !== want.last) begin
						err_cnt++;
						$display("%0t: last_in_run expected %0b actual %0b",
							$time, want.last, last_in_run);
					end
					if (bad_request !== want.bad) begin
						err_cnt++;
						$display("%0t: bad_request expected %0b actual %0b",
							$time, want.bad, bad_request);
					end
				end
			end
		end
		pend_cnt = expected_indices.size();
	end

endmodule

// ===== tb/tb_grid_mesh_index_generator.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the grid mesh index generator. All prediction and
// comparison lives in grid_mesh_index_checker; this module only drives.
module tb_grid_mesh_index_generator;
	import gmig_pkg::*;

	// Worst case is ~155 requests x 64 indices, each index held by a stall burst
	// from gap_len(), plus input gaps; the limit sits several times above that.
	localparam int LIMIT_CYCLES    = 1500000;
	// Slack after the last expected index, before the next register write.
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 11;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [DIV_W-1:0] cell_row = '0;
	logic [DIV_W-1:0] cell_column = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [IDX_W-1:0] vertex_index;
	logic             last_in_run;
	logic             bad_request;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = REG_COLS;
	logic [DIV_W-1:0] cfg_data = '0;

	int errors, pending, checked;
	int cycle_count = 0;
	int stall_run = 0;
	int quiet_run = 0;
	int requests_sent = 0;
	int grid_settings = 0;
	bit quiet_phase = 1'b0;

	logic [1:0] kind_list[4] = '{KIND_TSTRIP, KIND_TFAN, KIND_QSTRIP, KIND_QUAD};

	always #6 clk = ~clk;

	grid_mesh_index_generator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cell_row     (cell_row),
		.cell_column  (cell_column),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.last_in_run  (last_in_run),
		.bad_request  (bad_request),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	grid_mesh_index_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cell_row     (cell_row),
		.cell_column  (cell_column),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.last_in_run  (last_in_run),
		.bad_request  (bad_request),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked)
	);

	// Idle length: mostly the short range, now and then a long stretch.
	function automatic int gap_len();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// Division count for a random grid: favors the 1 and 31 extremes,
	// occasionally zero (no cells; requests checked on that axis are rejected).
	function automatic int pick_divs();
		int p;
		p = $urandom_range(0, 19);
		if (p == 0)
			return 0;
		if (p < 5)
			return 1;
		if (p < 9)
			return MAX_DIVISIONS;
		return $urandom_range(1, MAX_DIVISIONS);
	endfunction

	// Coordinate mostly inside the grid; about one in ten anywhere in 0..31
	// so out-of-grid requests keep showing up.
	function automatic logic [DIV_W-1:0] pick_coord(input int divs);
		int v;
		if (divs == 0 || $urandom_range(0, 9) == 0)
			v = $urandom_range(0, 31);
		else
			v = $urandom_range(0, divs - 1);
		return v[DIV_W-1:0];
	endfunction

	// Output side back-pressure. Random stall bursts, with quiet windows
	// where the output drains at full rate.
	always @(posedge clk) begin
		if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run--;
		end else begin
			out_stall <= 1'b0;
			if (quiet_run > 0)
				quiet_run--;
			else if ($urandom_range(0, 199) == 0)
				quiet_run = $urandom_range(50, 300);
			else if ($urandom_range(0, 2) == 0)
				stall_run = gap_len();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d indices still expected",
				cycle_count, pending);
			$display("tb_grid_mesh_index_generator: errors");
			$finish;
		end
	end

	// One request transaction. Valid rises after an optional gap and stays up,
	// payload stable, until the block takes it. Returns on the accepting edge
	// with valid still high so back-to-back requests need no dead cycle.
	task automatic send_cell(input logic [DIV_W-1:0] r, input logic [DIV_W-1:0] c);
		int gap;
		gap = 0;
		if (!quiet_phase && $urandom_range(0, 2) == 0)
			gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_row <= r;
		cell_column <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	// Drop valid and wait for every expected index, then DRAIN_CYCLES more so
	// the block is truly idle before the next register write.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back, one per cycle.
	task automatic set_grid(input int cols, input int rows, input logic [1:0] kind,
			input logic rule);
		cfg_we <= 1'b1;
		cfg_index <= REG_COLS;
		cfg_data <= cols[DIV_W-1:0];
		@(posedge clk);
		cfg_index <= REG_ROWS;
		cfg_data <= rows[DIV_W-1:0];
		@(posedge clk);
		cfg_index <= REG_KIND;
		cfg_data <= {{(DIV_W-2){1'b0}}, kind};
		@(posedge clk);
		cfg_index <= REG_RULE;
		cfg_data <= {{(DIV_W-1){1'b0}}, rule};
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_settings++;
	endtask

	initial begin
		int cols, rows;
		logic [1:0] kind;
		logic rule;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid: 10 x 10, row strips. Last row, row past the grid and a
		// row of 31; the column field is don't-care here.
		send_cell(5'd0, 5'd0);
		send_cell(5'd9, 5'd31);
		send_cell(5'd10, 5'd0);
		send_cell(5'd31, 5'd5);
		settle();

		// Largest column strips: 64 indices, last column reaches the index wrap.
		set_grid(MAX_DIVISIONS, MAX_DIVISIONS, KIND_TSTRIP, RULE_ULLR);
		send_cell(5'd0, 5'd0);
		send_cell(5'd17, 5'd30);
		send_cell(5'd0, 5'd31);
		settle();

		// Largest row strips, bottom row touches the top of the vertex pool.
		set_grid(MAX_DIVISIONS, MAX_DIVISIONS, KIND_TSTRIP, RULE_LLUR);
		send_cell(5'd30, 5'd0);
		send_cell(5'd31, 5'd0);
		settle();

		// Single-cell grid fans; each coordinate off the grid on its own.
		set_grid(1, 1, KIND_TFAN, RULE_LLUR);
		send_cell(5'd0, 5'd0);
		send_cell(5'd1, 5'd0);
		send_cell(5'd0, 5'd1);
		settle();

		set_grid(MAX_DIVISIONS, MAX_DIVISIONS, KIND_TFAN, RULE_ULLR);
		send_cell(5'd30, 5'd30);
		send_cell(5'd0, 5'd0);
		send_cell(5'd31, 5'd0);
		settle();

		// Quad strips ignore the row: row 31 is still a valid request.
		set_grid(7, MAX_DIVISIONS, KIND_QSTRIP, RULE_LLUR);
		send_cell(5'd31, 5'd6);
		send_cell(5'd0, 5'd7);
		settle();

		// Zero divisions on either axis: nothing lies inside the grid.
		set_grid(0, 5, KIND_QUAD, RULE_ULLR);
		send_cell(5'd0, 5'd0);
		settle();
		set_grid(MAX_DIVISIONS, 0, KIND_TSTRIP, RULE_LLUR);
		send_cell(5'd0, 5'd0);
		settle();

		set_grid(MAX_DIVISIONS, MAX_DIVISIONS, KIND_QUAD, RULE_LLUR);
		send_cell(5'd30, 5'd30);
		send_cell(5'd31, 5'd0);
		settle();

		// Random grids; kinds rotate so each one gets several phases.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			cols = pick_divs();
			rows = pick_divs();
			kind = kind_list[p % 4];
			rule = $urandom_range(0, 1) ? RULE_ULLR : RULE_LLUR;
			quiet_phase = ($urandom_range(0, 3) == 0);
			set_grid(cols, rows, kind, rule);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_cell(pick_coord(rows), pick_coord(cols));
			settle();
		end

		$display("covered %0d primitive requests over %0d grid settings",
			requests_sent, grid_settings);
		$display("%0d index transactions compared, %0d mismatches", checked, errors);
		if (errors == 0)
			$display("tb_grid_mesh_index_generator: clean");
		else
			$display("tb_grid_mesh_index_generator: errors");
		$finish;
	end

endmodule
